/* sv/sql_text_whitespace_normalizer_defines.svh */
// assertion macros used by the checker file
`ifndef SQL_TEXT_WHITESPACE_NORMALIZER_DEFINES_SVH
`define SQL_TEXT_WHITESPACE_NORMALIZER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SQLWN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sqlwn assertion failed");

// next-cycle implication, disabled while in reset
`define SQLWN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sqlwn assertion failed");

`endif

/* sv/sqlwn_pkg.sv */
`timescale 1ns / 1ps
package sqlwn_pkg;

	typedef logic [7:0] byte_t;

	typedef enum logic [3:0] {
		MODE_NORMAL  = 4'd0,
		MODE_SINGLE  = 4'd1,
		MODE_DOUBLE  = 4'd2,
		MODE_BTICK   = 4'd3,
		MODE_BRACKET = 4'd4,
		MODE_DASH    = 4'd5,
		MODE_SLASH   = 4'd6,
		MODE_LINE    = 4'd7,
		MODE_BLOCK   = 4'd8,
		MODE_BSTAR   = 4'd9
	} scan_mode_t;

	localparam int MaxRes = 3;
	localparam int CntW   = 2;

	localparam byte_t CH_SQUOTE = 8'h27;
	localparam byte_t CH_DQUOTE = 8'h22;
	localparam byte_t CH_BTICK  = 8'h60;
	localparam byte_t CH_LBRACK = 8'h5B;
	localparam byte_t CH_RBRACK = 8'h5D;
	localparam byte_t CH_DASH   = 8'h2D;
	localparam byte_t CH_SLASH  = 8'h2F;
	localparam byte_t CH_STAR   = 8'h2A;
	localparam byte_t CH_NL     = 8'h0A;
	localparam byte_t CH_LPAREN = 8'h28;
	localparam byte_t CH_RPAREN = 8'h29;
	localparam byte_t CH_COMMA  = 8'h2C;
	localparam byte_t CH_SPACE  = 8'h20;
	localparam byte_t CH_TAB    = 8'h09;
	localparam byte_t CH_VT     = 8'h0B;
	localparam byte_t CH_FF     = 8'h0C;
	localparam byte_t CH_CR     = 8'h0D;

	typedef struct packed {
		scan_mode_t mode;
		logic       space_pending;
		logic       any_emitted;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{mode: MODE_NORMAL, space_pending: 1'b0,
		any_emitted: 1'b0};

	// results of one byte, handed to the result buffer
	typedef struct packed {
		byte_t [MaxRes-1:0] bytes;
		logic [CntW-1:0]    cnt;
		logic               has_byte;
		logic               done;
	} step_res_t;

	typedef struct packed {
		scan_state_t        st;
		byte_t [MaxRes-1:0] bytes;
		logic [CntW-1:0]    n;
	} emit_acc_t;

	function automatic logic is_ws(byte_t c);
		return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
			c == CH_FF || c == CH_CR;
	endfunction

	function automatic emit_acc_t put_byte(emit_acc_t a, byte_t c);
		emit_acc_t r;
		r = a;
		if (r.n < CntW'(MaxRes)) begin
			r.bytes[r.n] = c;
			r.n = r.n + 1'b1;
		end
		r.st.any_emitted = 1'b1;
		return r;
	endfunction

	function automatic emit_acc_t plain_char(emit_acc_t a, byte_t c);
		emit_acc_t r;
		r = a;
		if (r.st.space_pending && r.st.any_emitted)
			r = put_byte(r, CH_SPACE);
		r.st.space_pending = 1'b0;
		r = put_byte(r, c);
		return r;
	endfunction

	function automatic emit_acc_t normal_byte(emit_acc_t a, byte_t c);
		emit_acc_t r;
		r = a;
		r.st.mode = MODE_NORMAL;
		if (c == CH_SQUOTE) begin
			r = plain_char(r, c);
			r.st.mode = MODE_SINGLE;
		end else if (c == CH_DQUOTE) begin
			r = plain_char(r, c);
			r.st.mode = MODE_DOUBLE;
		end else if (c == CH_BTICK) begin
			r = plain_char(r, c);
			r.st.mode = MODE_BTICK;
		end else if (c == CH_LBRACK) begin
			r = plain_char(r, c);
			r.st.mode = MODE_BRACKET;
		end else if (is_ws(c)) begin
			r.st.space_pending = 1'b1;
		end else if (c == CH_DASH) begin
			r.st.mode = MODE_DASH;
		end else if (c == CH_SLASH) begin
			r.st.mode = MODE_SLASH;
		end else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_COMMA) begin
			r.st.space_pending = 1'b0;
			r = put_byte(r, c);
		end else begin
			r = plain_char(r, c);
		end
		return r;
	endfunction

endpackage

/* sv/sqlwn_if.sv */
`timescale 1ns / 1ps
interface sqlwn_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sqlwn_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       text_done;
	logic       last_of_run;

	modport source (output valid, output out_byte, output has_byte, output text_done,
		output last_of_run, input ready);
	modport sink (input valid, input out_byte, input has_byte, input text_done,
		input last_of_run, output ready);
endinterface

/* sv/sqlwn_step.sv */
`timescale 1ns / 1ps
module sqlwn_step (
	input  sqlwn_pkg::scan_state_t st,
	input  sqlwn_pkg::byte_t       c,
	input  logic                   eot,
	output sqlwn_pkg::step_res_t   res,
	output sqlwn_pkg::scan_state_t st_next
);
	import sqlwn_pkg::*;

	emit_acc_t acc;

	always_comb begin
		acc = '0;
		acc.st = st;
		unique case (st.mode)
			MODE_SINGLE: begin
				acc = put_byte(acc, c);
				if (c == CH_SQUOTE) acc.st.mode = MODE_NORMAL;
			end
			MODE_DOUBLE: begin
				acc = put_byte(acc, c);
				if (c == CH_DQUOTE) acc.st.mode = MODE_NORMAL;
			end
			MODE_BTICK: begin
				acc = put_byte(acc, c);
				if (c == CH_BTICK) acc.st.mode = MODE_NORMAL;
			end
			MODE_BRACKET: begin
				acc = put_byte(acc, c);
				if (c == CH_RBRACK) acc.st.mode = MODE_NORMAL;
			end
			MODE_DASH: begin
				if (c == CH_DASH) begin
					acc.st.mode = MODE_LINE;
				end else begin
					acc = plain_char(acc, CH_DASH);
					acc = normal_byte(acc, c);
				end
			end
			MODE_SLASH: begin
				if (c == CH_STAR) begin
					acc.st.mode = MODE_BLOCK;
				end else begin
					acc = plain_char(acc, CH_SLASH);
					acc = normal_byte(acc, c);
				end
			end
			MODE_LINE: begin
				if (c == CH_NL) begin
					acc.st.mode = MODE_NORMAL;
					acc.st.space_pending = 1'b1;
				end
			end
			MODE_BLOCK: begin
				if (c == CH_STAR) acc.st.mode = MODE_BSTAR;
			end
			MODE_BSTAR: begin
				if (c == CH_SLASH) begin
					acc.st.mode = MODE_NORMAL;
					acc.st.space_pending = 1'b1;
				end else if (c != CH_STAR) begin
					acc.st.mode = MODE_BLOCK;
				end
			end
			default: acc = normal_byte(acc, c);
		endcase

		// a dash or slash still held at the end goes out as a plain byte
		if (eot) begin
			if (acc.st.mode == MODE_DASH) acc = plain_char(acc, CH_DASH);
			else if (acc.st.mode == MODE_SLASH) acc = plain_char(acc, CH_SLASH);
		end
	end

	always_comb begin
		res.done = eot;
		if (eot && acc.n == '0) begin
			// bare end marker
			res.bytes    = '0;
			res.cnt      = CntW'(1);
			res.has_byte = 1'b0;
		end else begin
			res.bytes    = acc.bytes;
			res.cnt      = acc.n;
			res.has_byte = 1'b1;
		end
		st_next = eot ? SCAN_RESET : acc.st;
	end

endmodule

/* sv/sqlwn_res_buf.sv */
`timescale 1ns / 1ps
module sqlwn_res_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  sqlwn_pkg::step_res_t res,
	output logic                 free,
	sqlwn_out_if.source          text_out
);
	import sqlwn_pkg::*;

	logic               valid_q;
	logic [CntW-1:0]    idx_q;
	logic [CntW-1:0]    idx_inc;
	byte_t [MaxRes-1:0] bytes_q;
	logic [CntW-1:0]    cnt_q;
	logic               has_q;
	logic               done_q;
	logic               last;
	logic               fire;

	assign idx_inc = idx_q + 1'b1;
	assign last    = idx_inc == cnt_q;
	assign fire    = valid_q && text_out.ready;
	assign free    = !valid_q || (fire && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (fire) begin
			if (last) valid_q <= 1'b0;
			else idx_q <= idx_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
			cnt_q   <= res.cnt;
			has_q   <= res.has_byte;
			done_q  <= res.done;
		end
	end

	assign text_out.valid       = valid_q;
	assign text_out.out_byte    = has_q ? bytes_q[idx_q] : '0;
	assign text_out.has_byte    = has_q;
	assign text_out.last_of_run = last;
	assign text_out.text_done   = done_q && last;

endmodule

/* sv/sql_text_whitespace_normalizer.sv */
`timescale 1ns / 1ps
// channel    dir  beat payload
// text_in    in   text_byte[7:0], end_of_text
// text_out   out  out_byte[7:0], has_byte, text_done, last_of_run
//
// one input byte per cycle when not stalled; a byte with more than one
// result (at most three) holds the input while the result buffer drains
// first result beat is offered via the input register and result buffer
// reset clears the scanner state and both valid flags
// text_in stalls only while the byte in the input register has results
// and the result buffer has not yet handed out its last beat
module sql_text_whitespace_normalizer (
	input logic         clk,
	input logic         arst_n,
	sqlwn_in_if.sink    text_in,
	sqlwn_out_if.source text_out
);
	import sqlwn_pkg::*;

	logic        valid_s1;
	byte_t       byte_s1;
	logic        end_s1;
	scan_state_t st_q;
	scan_state_t st_next;
	step_res_t   res;
	logic        buf_free;
	logic        advance;
	logic        load;

	sqlwn_step u_step (
		.st      (st_q),
		.c       (byte_s1),
		.eot     (end_s1),
		.res     (res),
		.st_next (st_next)
	);

	// bytes with no result move on without touching the buffer
	assign advance = valid_s1 && (res.cnt == '0 || buf_free);
	assign load    = valid_s1 && res.cnt != '0 && buf_free;

	assign text_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= SCAN_RESET;
		end else begin
			if (text_in.ready) valid_s1 <= text_in.valid;
			if (advance) st_q <= st_next;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			byte_s1 <= text_in.text_byte;
			end_s1  <= text_in.end_of_text;
		end
	end

	sqlwn_res_buf u_res_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.free     (buf_free),
		.text_out (text_out)
	);

endmodule

/* sv/sqlwn_checker.sv */
`timescale 1ns / 1ps
`include "sql_text_whitespace_normalizer_defines.svh"
module sqlwn_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       has_byte,
	input logic       text_done,
	input logic       last_of_run
);

	`SQLWN_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`SQLWN_ASSERT_NOW(a_done_is_last, clk, arst_n, out_valid && text_done, last_of_run)
	`SQLWN_ASSERT_NOW(a_bare_marker, clk, arst_n, out_valid && !has_byte, text_done && out_byte == 8'h00)
	// the rest of a run follows in the next cycle with no gap
	`SQLWN_ASSERT_NEXT(a_run_cont, clk, arst_n, out_valid && out_ready && !last_of_run, out_valid && has_byte)

endmodule

bind sql_text_whitespace_normalizer sqlwn_checker u_sqlwn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (text_out.valid),
	.out_ready   (text_out.ready),
	.out_byte    (text_out.out_byte),
	.has_byte    (text_out.has_byte),
	.text_done   (text_out.text_done),
	.last_of_run (text_out.last_of_run)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import sqlwn_pkg::*;

	localparam int NumRandBytes = 180;
	localparam int CycleLimit   = 200000;

	typedef struct packed {
		byte_t out_byte;
		logic  has_byte;
		logic  text_done;
		logic  last_of_run;
	} beat_t;

	typedef struct packed {
		byte_t txt;
		logic  eot;
		logic  typed;
		beat_t want;
	} row_t;

	localparam beat_t NO_BEAT = '0;
	localparam byte_t CH_LOW_B = 8'h62;

	// typed rows: bare end marker, byte extremes at end and mid text; rest use scanner copy
	localparam row_t DirRows[27] = '{
		'{CH_SPACE,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
		'{8'hFF,     1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}},
		'{8'h00,     1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
		'{CH_SPACE,  1'b0, 1'b0, NO_BEAT},
		'{CH_DASH,   1'b0, 1'b0, NO_BEAT},
		'{CH_LOW_B,  1'b0, 1'b0, NO_BEAT},
		'{CH_TAB,    1'b0, 1'b0, NO_BEAT},
		'{CH_LPAREN, 1'b0, 1'b0, NO_BEAT},
		'{CH_DQUOTE, 1'b0, 1'b0, NO_BEAT},
		'{CH_DQUOTE, 1'b0, 1'b0, NO_BEAT},
		'{CH_DQUOTE, 1'b0, 1'b0, NO_BEAT},
		'{CH_DQUOTE, 1'b0, 1'b0, NO_BEAT},
		'{CH_BTICK,  1'b0, 1'b0, NO_BEAT},
		'{CH_BTICK,  1'b0, 1'b0, NO_BEAT},
		'{CH_LBRACK, 1'b0, 1'b0, NO_BEAT},
		'{CH_RBRACK, 1'b0, 1'b0, NO_BEAT},
		'{CH_SQUOTE, 1'b0, 1'b0, NO_BEAT},
		'{CH_SQUOTE, 1'b0, 1'b0, NO_BEAT},
		'{CH_COMMA,  1'b0, 1'b0, NO_BEAT},
		'{CH_DASH,   1'b0, 1'b0, NO_BEAT},
		'{CH_DASH,   1'b0, 1'b0, NO_BEAT},
		'{CH_NL,     1'b0, 1'b0, NO_BEAT},
		'{CH_SLASH,  1'b0, 1'b0, NO_BEAT},
		'{CH_STAR,   1'b0, 1'b0, NO_BEAT},
		'{CH_STAR,   1'b0, 1'b0, NO_BEAT},
		'{CH_SLASH,  1'b0, 1'b0, NO_BEAT},
		'{CH_SLASH,  1'b1, 1'b0, NO_BEAT}
	};

	logic clk;
	logic arst_n;

	sqlwn_in_if  text_in();
	sqlwn_out_if text_out();

	sql_text_whitespace_normalizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.text_out (text_out)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// scanner copy kept by the testbench
	scan_mode_t scan_mode;
	logic       gap_pending;
	logic       emitted;
	byte_t      burst[MaxRes];
	int         burst_n;
	beat_t      step_beats[$];
	beat_t      canon_q[$];
	beat_t      canon_want;

	int src_idle_pct;
	int snk_stall_pct;
	int n_err;
	int n_sent;
	int cycles;

	function automatic logic is_blank(byte_t c);
		return c inside {CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
	endfunction

	function void emit_char(byte_t c);
		if (burst_n < MaxRes) begin
			burst[burst_n] = c;
			burst_n++;
		end
		emitted = 1'b1;
	endfunction

	function void emit_spaced(byte_t c);
		if (gap_pending && emitted)
			emit_char(CH_SPACE);
		gap_pending = 1'b0;
		emit_char(c);
	endfunction

	function void scan_plain(byte_t c);
		scan_mode = MODE_NORMAL;
		if (c == CH_SQUOTE) begin
			emit_spaced(c);
			scan_mode = MODE_SINGLE;
		end else if (c == CH_DQUOTE) begin
			emit_spaced(c);
			scan_mode = MODE_DOUBLE;
		end else if (c == CH_BTICK) begin
			emit_spaced(c);
			scan_mode = MODE_BTICK;
		end else if (c == CH_LBRACK) begin
			emit_spaced(c);
			scan_mode = MODE_BRACKET;
		end else if (is_blank(c)) begin
			gap_pending = 1'b1;
		end else if (c == CH_DASH) begin
			scan_mode = MODE_DASH;
		end else if (c == CH_SLASH) begin
			scan_mode = MODE_SLASH;
		end else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_COMMA) begin
			// no space before punctuation, pending gap dropped
			gap_pending = 1'b0;
			emit_char(c);
		end else begin
			emit_spaced(c);
		end
	endfunction

	function void normalize_byte(byte_t c, logic eot);
		beat_t b;
		burst_n = 0;
		step_beats.delete();
		case (scan_mode)
			MODE_SINGLE: begin
				emit_char(c);
				if (c == CH_SQUOTE) scan_mode = MODE_NORMAL;
			end
			MODE_DOUBLE: begin
				emit_char(c);
				if (c == CH_DQUOTE) scan_mode = MODE_NORMAL;
			end
			MODE_BTICK: begin
				emit_char(c);
				if (c == CH_BTICK) scan_mode = MODE_NORMAL;
			end
			MODE_BRACKET: begin
				emit_char(c);
				if (c == CH_RBRACK) scan_mode = MODE_NORMAL;
			end
			MODE_DASH: begin
				if (c == CH_DASH) begin
					scan_mode = MODE_LINE;
				end else begin
					emit_spaced(CH_DASH);
					scan_plain(c);
				end
			end
			MODE_SLASH: begin
				if (c == CH_STAR) begin
					scan_mode = MODE_BLOCK;
				end else begin
					emit_spaced(CH_SLASH);
					scan_plain(c);
				end
			end
			MODE_LINE: begin
				if (c == CH_NL) begin
					scan_mode = MODE_NORMAL;
					gap_pending = 1'b1;
				end
			end
			MODE_BLOCK: begin
				if (c == CH_STAR) scan_mode = MODE_BSTAR;
			end
			MODE_BSTAR: begin
				if (c == CH_SLASH) begin
					scan_mode = MODE_NORMAL;
					gap_pending = 1'b1;
				end else if (c != CH_STAR) begin
					scan_mode = MODE_BLOCK;
				end
			end
			default: scan_plain(c);
		endcase
		// a held dash or slash at end of text goes out as a plain byte
		if (eot) begin
			if (scan_mode == MODE_DASH) emit_spaced(CH_DASH);
			else if (scan_mode == MODE_SLASH) emit_spaced(CH_SLASH);
		end
		for (int k = 0; k < burst_n; k++) begin
			b.out_byte    = burst[k];
			b.has_byte    = 1'b1;
			b.last_of_run = (k == burst_n - 1);
			b.text_done   = (k == burst_n - 1) && eot;
			step_beats.push_back(b);
		end
		if (eot && burst_n == 0)
			step_beats.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
		if (eot) begin
			scan_mode   = MODE_NORMAL;
			gap_pending = 1'b0;
			emitted     = 1'b0;
		end
	endfunction

	function automatic byte_t pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 22) return 8'h61 + byte_t'($urandom_range(25));
		if (r < 36) begin
			case ($urandom_range(5))
				0: return CH_SPACE;
				1: return CH_TAB;
				2: return CH_NL;
				3: return CH_VT;
				4: return CH_FF;
				default: return CH_CR;
			endcase
		end
		if (r < 50) begin
			case ($urandom_range(4))
				0: return CH_SQUOTE;
				1: return CH_DQUOTE;
				2: return CH_BTICK;
				3: return CH_LBRACK;
				default: return CH_RBRACK;
			endcase
		end
		if (r < 62) return $urandom_range(1) ? CH_DASH : CH_SLASH;
		if (r < 68) return CH_STAR;
		if (r < 78) begin
			case ($urandom_range(3))
				0: return CH_LPAREN;
				1: return CH_RPAREN;
				2: return CH_COMMA;
				default: return CH_NL;
			endcase
		end
		return byte_t'($urandom_range(255));
	endfunction

	// sql-ish text: single bytes mixed with comment openers/closers and quote pairs
	task automatic build_text(ref byte_t txt[$]);
		int len;
		len = $urandom_range(1, 14);
		txt.delete();
		while (txt.size() < len) begin
			case ($urandom_range(9))
				0: begin txt.push_back(CH_DASH); txt.push_back(CH_DASH); end
				1: begin txt.push_back(CH_SLASH); txt.push_back(CH_STAR); end
				2: begin txt.push_back(CH_STAR); txt.push_back(CH_SLASH); end
				3: begin txt.push_back(CH_SQUOTE); txt.push_back(CH_SQUOTE); end
				default: txt.push_back(pick_char());
			endcase
		end
	endtask

	task automatic send_byte(byte_t c, logic eot, logic typed, beat_t want);
		logic fire;
		while ($urandom_range(99) < src_idle_pct) begin
			text_in.valid <= 1'b0;
			@(posedge clk);
		end
		text_in.valid       <= 1'b1;
		text_in.text_byte   <= c;
		text_in.end_of_text <= eot;
		normalize_byte(c, eot);
		if (typed) begin
			canon_q.push_back(want);
		end else begin
			foreach (step_beats[i]) canon_q.push_back(step_beats[i]);
		end
		fire = 1'b0;
		while (!fire) begin
			@(negedge clk);
			fire = text_in.ready;
			@(posedge clk);
		end
		n_sent++;
	endtask

	initial begin
		int    ph;
		byte_t txt[$];
		text_in.valid       <= 1'b0;
		text_in.text_byte   <= 8'h00;
		text_in.end_of_text <= 1'b0;
		arst_n              <= 1'b0;
		scan_mode     = MODE_NORMAL;
		gap_pending   = 1'b0;
		emitted       = 1'b0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		n_err         = 0;
		n_sent        = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DirRows[i])
			send_byte(DirRows[i].txt, DirRows[i].eot, DirRows[i].typed, DirRows[i].want);
		while (n_sent < $size(DirRows) + NumRandBytes) begin
			ph = (n_sent - $size(DirRows)) * 4 / NumRandBytes;
			case (ph)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
				default: begin src_idle_pct = 21; snk_stall_pct = 21; end
			endcase
			build_text(txt);
			foreach (txt[i])
				send_byte(txt[i], i == txt.size() - 1, 1'b0, NO_BEAT);
		end
		text_in.valid <= 1'b0;
		while (canon_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (n_err == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		text_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			text_out.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// handshake signals only move at the rising edge, so sample them mid cycle
	always @(negedge clk) begin
		if (arst_n && text_out.valid && text_out.ready) begin
			if (canon_q.size() == 0) begin
				$error("unexpected beat: out_byte %h has_byte %b", text_out.out_byte,
					text_out.has_byte);
				n_err++;
			end else begin
				canon_want = canon_q.pop_front();
				if (text_out.out_byte !== canon_want.out_byte) begin
					$error("out_byte: expected %h, got %h", canon_want.out_byte,
						text_out.out_byte);
					n_err++;
				end
				if (text_out.has_byte !== canon_want.has_byte) begin
					$error("has_byte: expected %b, got %b", canon_want.has_byte,
						text_out.has_byte);
					n_err++;
				end
				if (text_out.text_done !== canon_want.text_done) begin
					$error("text_done: expected %b, got %b", canon_want.text_done,
						text_out.text_done);
					n_err++;
				end
				if (text_out.last_of_run !== canon_want.last_of_run) begin
					$error("last_of_run: expected %b, got %b", canon_want.last_of_run,
						text_out.last_of_run);
					n_err++;
				end
			end
		end
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule

/* files.f */
+incdir+sv
sv/sqlwn_pkg.sv
sv/sqlwn_if.sv
sv/sqlwn_step.sv
sv/sqlwn_res_buf.sv
sv/sql_text_whitespace_normalizer.sv
sv/sqlwn_checker.sv
tb/sv/tb_top.sv
